/* design/ordered_array_list_assert.svh */
// Assertion macros for the ordered array list block.
`ifndef ORDERED_ARRAY_LIST_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ASSERT_SVH
`ifndef SYNTHESIS
`define OAL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered_array_list assertion failed");
`define OAL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered_array_list assertion failed");
`else
`define OAL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OAL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/oal_pkg.sv */
// Shared types, constants and command/status structs of the ordered array list.
package oal_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int POS_W   = 6;
    localparam int FOUND_W = 6;
    localparam int COUNT_W = 7;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [CMP_W-1:0]   cmp_t;
    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [FOUND_W-1:0] found_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [1:0] {
        REQ_APPEND,
        REQ_INSERT,
        REQ_DELETE,
        REQ_FIND
    } req_code_t;

    typedef enum logic [2:0] {
        ST_DONE,
        ST_FULL,
        ST_EMPTY,
        ST_BADPOS,
        ST_NOTFOUND
    } status_t;

    typedef struct packed {
        req_code_t                 req_type;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  value;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic [FOUND_W-1:0]        found_index;
        logic [COUNT_W-1:0]        count;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        WR_AT_COUNT,
        WR_AT_POS,
        WR_SHIFT
    } wr_src_t;

    typedef struct packed {
        logic    load_req;
        logic    rd_en;
        logic    wr_en;
        wr_src_t wr_src;
        logic    idx_inc;
        logic    idx_dec;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_result;
        status_t result;
        logic    set_found;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        req_code_t req_type;
        logic      full;
        logic      empty;
        logic      ins_bad;
        logic      del_bad;
        logic      ins_more;
        logic      del_more;
        logic      find_more;
        logic      match;
    } dp_sts_t;

endpackage

/* design/oal_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module oal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/oal_dp.sv */
// Datapath: request capture, count and index registers, element store, result register.
module oal_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  oal_pkg::req_t  req,
    input  oal_pkg::cmd_t  cmd,
    output oal_pkg::dp_sts_t sts,
    output oal_pkg::rsp_t  rsp
);

    oal_pkg::req_t    req_reg;
    oal_pkg::cnt_t    count_reg;
    oal_pkg::cnt_t    count_next;
    oal_pkg::cnt_t    idx_reg;
    oal_pkg::cnt_t    idx_next;
    oal_pkg::status_t status_reg;
    oal_pkg::found_t  found_reg;
    oal_pkg::rsp_t    rsp_reg;

    oal_pkg::data_t   rdata;
    oal_pkg::idx_t    raddr;
    oal_pkg::idx_t    waddr;
    oal_pkg::data_t   wdata;
    oal_pkg::cmp_t    pos_ext;
    oal_pkg::cmp_t    cnt_ext;
    oal_pkg::cmp_t    idx_ext;

    assign pos_ext = oal_pkg::cmp_t'(req_reg.position);
    assign cnt_ext = oal_pkg::cmp_t'(count_reg);
    assign idx_ext = oal_pkg::cmp_t'(idx_reg);

    always_comb
    begin
        sts.req_type  = req_reg.req_type;
        sts.full      = (count_reg == oal_pkg::cnt_t'(oal_pkg::DEPTH));
        sts.empty     = (count_reg == '0);
        sts.ins_bad   = (pos_ext > cnt_ext);
        sts.del_bad   = (pos_ext >= cnt_ext);
        sts.ins_more  = (idx_ext > pos_ext);
        sts.del_more  = ((idx_ext + oal_pkg::cmp_t'(1)) < cnt_ext);
        sts.find_more = (idx_ext < cnt_ext);
        sts.match     = (rdata == oal_pkg::data_t'(req_reg.value));
    end

    always_comb
    begin
        case (req_reg.req_type)
            oal_pkg::REQ_INSERT: raddr = oal_pkg::idx_t'(idx_reg - oal_pkg::cnt_t'(1));
            oal_pkg::REQ_DELETE: raddr = oal_pkg::idx_t'(idx_reg + oal_pkg::cnt_t'(1));
            default:             raddr = oal_pkg::idx_t'(idx_reg);
        endcase
    end

    always_comb
    begin
        case (cmd.wr_src)
            oal_pkg::WR_AT_COUNT:
            begin
                waddr = oal_pkg::idx_t'(count_reg);
                wdata = oal_pkg::data_t'(req_reg.value);
            end
            oal_pkg::WR_AT_POS:
            begin
                waddr = oal_pkg::idx_t'(req_reg.position);
                wdata = oal_pkg::data_t'(req_reg.value);
            end
            oal_pkg::WR_SHIFT:
            begin
                waddr = oal_pkg::idx_t'(idx_reg);
                wdata = rdata;
            end
            default:
            begin
                waddr = oal_pkg::idx_t'(idx_reg);
                wdata = rdata;
            end
        endcase
    end

    oal_ram #(
        .WIDTH (oal_pkg::DATA_W),
        .DEPTH (oal_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load_req)
        begin
            case (req.req_type)
                oal_pkg::REQ_INSERT: idx_next = count_reg;
                oal_pkg::REQ_DELETE: idx_next = oal_pkg::cnt_t'(req.position);
                default:             idx_next = '0;
            endcase
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + oal_pkg::cnt_t'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - oal_pkg::cnt_t'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + oal_pkg::cnt_t'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - oal_pkg::cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.set_result)
        begin
            status_reg <= cmd.result;
            found_reg  <= cmd.set_found ? oal_pkg::found_t'(idx_reg) : '0;
        end
        if (cmd.out_load)
        begin
            rsp_reg.status      <= status_reg;
            rsp_reg.found_index <= found_reg;
            rsp_reg.count       <= oal_pkg::count_t'(count_reg);
        end
    end

    assign rsp = rsp_reg;

endmodule

/* design/oal_ctrl.sv */
// Controller: sequences each request through the store and owns the result beat's valid.
module oal_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    input  oal_pkg::dp_sts_t sts,
    output oal_pkg::cmd_t    cmd
);

    oal_pkg::state_t state_reg;
    oal_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oal_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_src = oal_pkg::WR_SHIFT;
        cmd.result = oal_pkg::ST_DONE;

        case (state_reg)
            oal_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = oal_pkg::S_DECODE;
                end
            end

            oal_pkg::S_DECODE:
            begin
                case (sts.req_type)
                    oal_pkg::REQ_APPEND:
                    begin
                        cmd.set_result = 1'b1;
                        state_next     = oal_pkg::S_RESP;
                        if (sts.full)
                        begin
                            cmd.result = oal_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_src  = oal_pkg::WR_AT_COUNT;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    oal_pkg::REQ_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_result = 1'b1;
                            cmd.result     = oal_pkg::ST_FULL;
                            state_next     = oal_pkg::S_RESP;
                        end
                        else if (sts.ins_bad)
                        begin
                            cmd.set_result = 1'b1;
                            cmd.result     = oal_pkg::ST_BADPOS;
                            state_next     = oal_pkg::S_RESP;
                        end
                        else
                        begin
                            state_next = oal_pkg::S_INS_RD;
                        end
                    end
                    oal_pkg::REQ_DELETE:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_result = 1'b1;
                            cmd.result     = oal_pkg::ST_EMPTY;
                            state_next     = oal_pkg::S_RESP;
                        end
                        else if (sts.del_bad)
                        begin
                            cmd.set_result = 1'b1;
                            cmd.result     = oal_pkg::ST_BADPOS;
                            state_next     = oal_pkg::S_RESP;
                        end
                        else
                        begin
                            state_next = oal_pkg::S_DEL_RD;
                        end
                    end
                    default:
                    begin
                        state_next = oal_pkg::S_FIND_RD;
                    end
                endcase
            end

            oal_pkg::S_INS_RD:
            begin
                if (sts.ins_more)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = oal_pkg::S_INS_WR;
                end
                else
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_src     = oal_pkg::WR_AT_POS;
                    cmd.cnt_inc    = 1'b1;
                    cmd.set_result = 1'b1;
                    state_next     = oal_pkg::S_RESP;
                end
            end

            oal_pkg::S_INS_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.idx_dec = 1'b1;
                state_next  = oal_pkg::S_INS_RD;
            end

            oal_pkg::S_DEL_RD:
            begin
                if (sts.del_more)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = oal_pkg::S_DEL_WR;
                end
                else
                begin
                    cmd.cnt_dec    = 1'b1;
                    cmd.set_result = 1'b1;
                    state_next     = oal_pkg::S_RESP;
                end
            end

            oal_pkg::S_DEL_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = oal_pkg::S_DEL_RD;
            end

            oal_pkg::S_FIND_RD:
            begin
                if (sts.find_more)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = oal_pkg::S_FIND_CMP;
                end
                else
                begin
                    cmd.set_result = 1'b1;
                    cmd.result     = oal_pkg::ST_NOTFOUND;
                    state_next     = oal_pkg::S_RESP;
                end
            end

            oal_pkg::S_FIND_CMP:
            begin
                if (sts.match)
                begin
                    cmd.set_result = 1'b1;
                    cmd.set_found  = 1'b1;
                    state_next     = oal_pkg::S_RESP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = oal_pkg::S_FIND_RD;
                end
            end

            oal_pkg::S_RESP:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = oal_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = oal_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign req_stall = (state_reg != oal_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

/* design/ordered_array_list.sv */
// Top level of the ordered array list: controller, datapath and checks.
// From the accepting edge to the result beat valid: append and failed requests go from DECODE
//   straight to RESP; insert shifts entries from count down to position, then writes the value;
//   delete shifts the entries above position down; find scans from index 0 to a hit or the end.
//   Each shifted or scanned entry takes a read and a write or compare state. Throughput: one
//   request at a time, the next taken in the cycle after the result beat loads; a new one is
//   taken while that beat waits. Reset: count and control clear at once; store contents not cleared.
`include "ordered_array_list_assert.svh"

module ordered_array_list (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  oal_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output oal_pkg::rsp_t rsp
);

    oal_pkg::cmd_t    cmd;
    oal_pkg::dp_sts_t sts;

    oal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    oal_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

    `OAL_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)
    `OAL_ASSERT_IMP(a_count_bound, clk, rst_n, rsp_valid, rsp.count <= oal_pkg::DEPTH)
    `OAL_ASSERT_IMP(a_found_zero_on_fail, clk, rst_n,
                    rsp_valid && rsp.status != oal_pkg::ST_DONE, rsp.found_index == '0)
    `OAL_ASSERT_IMP(a_single_store_op, clk, rst_n, cmd.wr_en, !cmd.rd_en)

endmodule
